// ----- rtl/c2s_pkg.sv -----
package c2s_pkg;

	localparam int COORD_BITS        = 18;
	localparam int ANGLE_FRAC_BITS   = 7;
	localparam int CORDIC_ITERATIONS = 18;

	localparam int COORD_GUARD = 8;
	localparam int ANGLE_GUARD = 12;
	localparam int ANGLE_F     = ANGLE_FRAC_BITS + ANGLE_GUARD;
	localparam int TABLE_LEN   = 32;
	localparam int ITERS       = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;

	localparam int XY_W   = COORD_BITS + COORD_GUARD + 3;
	localparam int ANG_W  = ANGLE_F + 10;
	localparam int SIDE_W = COORD_BITS + COORD_GUARD;
	localparam int RND_W  = ANG_W - ANGLE_GUARD + 1;
	localparam int AZ_W   = 16;
	localparam int EL_W   = 15;
	localparam int DIST_W = 18;

	typedef logic signed [XY_W-1:0]  xy_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [RND_W-1:0] rnd_t;
	typedef logic signed [EL_W-1:0]  el_t;
	typedef logic [ITERS-1:0][ANG_W-1:0] atan_tab_t;

	localparam logic [31:0] INV_GAIN       = 32'h9B74_EDA8;
	localparam logic [63:0] RAD_TO_DEG_Q30 = 64'd61520874802;

	localparam ang_t HALF_TURN_F  = ang_t'(180) <<< ANGLE_F;
	localparam ang_t ANG_RND_HALF = ang_t'(1) <<< (ANGLE_GUARD - 1);
	localparam rnd_t FULL_TURN    = rnd_t'(360) <<< ANGLE_FRAC_BITS;
	localparam rnd_t QUARTER_TURN = rnd_t'(90) <<< ANGLE_FRAC_BITS;
	localparam el_t  EL_MAX       = el_t'(QUARTER_TURN);
	localparam el_t  EL_MIN       = -EL_MAX;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// elaboration-time long division for the series terms
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in degrees, ANGLE_F fraction bits, via the arctangent series
	function automatic logic [ANG_W-1:0] atan_entry(input int i);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] rad28;
		logic [63:0] prod;
		logic [63:0] k;
		logic [63:0] res;
		p   = 64'd1 << (60 - i);
		sum = '0;
		k   = '0;
		if (i == 0) begin
			res = 64'd45 << ANGLE_F;
		end else begin
			for (int it = 0; it < 64; it++) begin
				if (p != 64'd0) begin
					term = udiv64(p, (k << 1) + 64'd1);
					if (!k[0])
						sum = sum + term;
					else
						sum = sum - term;
					p = p >> (2 * i);
					k = k + 64'd1;
				end
			end
			rad28 = (sum + (64'd1 << 31)) >> 32;
			prod  = rad28 * RAD_TO_DEG_Q30;
			res   = (prod + (64'd1 << (57 - ANGLE_F))) >> (58 - ANGLE_F);
		end
		return res[ANG_W-1:0];
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		for (int i = 0; i < ITERS; i++)
			tab[i] = atan_entry(i);
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

// ----- rtl/c2s_gain.sv -----
module c2s_gain (
	input  logic                       clk,
	input  logic                       advance,
	input  logic [c2s_pkg::XY_W-1:0]   value,
	output logic [c2s_pkg::XY_W-1:0]   scaled
);

	localparam int PROD_W = c2s_pkg::XY_W + 32;

	logic [PROD_W-1:0] prod;

	// round(value * 1/K), half up
	always_comb begin
		prod = {32'b0, value} * {{c2s_pkg::XY_W{1'b0}}, c2s_pkg::INV_GAIN}
			+ PROD_W'(64'h8000_0000);
	end

	always_ff @(posedge clk) begin
		if (advance)
			scaled <= prod[PROD_W-1:32];
	end

endmodule

// ----- rtl/c2s_cordic_pass.sv -----
module c2s_cordic_pass (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        src_valid,
	input  c2s_pkg::xy_t                src_x,
	input  c2s_pkg::xy_t                src_y,
	input  logic [c2s_pkg::SIDE_W-1:0]  src_side,
	output logic                        dst_valid,
	output c2s_pkg::xy_t                dst_x,
	output c2s_pkg::ang_t               dst_angle,
	output logic [c2s_pkg::SIDE_W-1:0]  dst_side
);

	localparam int N = c2s_pkg::ITERS;

	c2s_pkg::xy_t               x_s    [N+1];
	c2s_pkg::xy_t               y_s    [N+1];
	c2s_pkg::ang_t              ang_s  [N+1];
	logic [c2s_pkg::SIDE_W-1:0] side_s [N+1];
	logic [N:0]                 zero_s;
	logic [N:0]                 valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= '0;
		else if (advance)
			valid_s <= {valid_s[N-1:0], src_valid};
	end

	// left half-plane folded onto the right, 180 degrees pre-loaded
	always_ff @(posedge clk) begin
		if (advance) begin
			zero_s[0] <= (src_x == '0) && (src_y == '0);
			side_s[0] <= src_side;
			if (src_x[c2s_pkg::XY_W-1]) begin
				x_s[0]   <= -src_x;
				y_s[0]   <= -src_y;
				ang_s[0] <= c2s_pkg::HALF_TURN_F;
			end else begin
				x_s[0]   <= src_x;
				y_s[0]   <= src_y;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		c2s_pkg::xy_t  dx;
		c2s_pkg::xy_t  dy;
		c2s_pkg::ang_t step;

		assign dx   = y_s[k] >>> k;
		assign dy   = x_s[k] >>> k;
		assign step = $signed(c2s_pkg::ATAN_TAB[k]);

		always_ff @(posedge clk) begin
			if (advance) begin
				zero_s[k+1] <= zero_s[k];
				side_s[k+1] <= side_s[k];
				if (!y_s[k][c2s_pkg::XY_W-1]) begin
					x_s[k+1]   <= x_s[k] + dx;
					y_s[k+1]   <= y_s[k] - dy;
					ang_s[k+1] <= ang_s[k] + step;
				end else begin
					x_s[k+1]   <= x_s[k] - dx;
					y_s[k+1]   <= y_s[k] + dy;
					ang_s[k+1] <= ang_s[k] - step;
				end
			end
		end
	end

	assign dst_valid = valid_s[N];
	assign dst_x     = x_s[N];
	assign dst_angle = zero_s[N] ? '0 : ang_s[N];
	assign dst_side  = side_s[N];

endmodule

// ----- rtl/cartesian_to_spherical_core.sv -----
// channel  dir  transfer when          payload
// point    in   pt_valid & pt_ready    x_coord y_coord z_coord
// result   out  res_valid & res_ready  azimuth elevation distance
//
// One point enters per cycle while pt_ready is high.
// The unrolled CORDIC stages of the two vectoring passes set the depth.
// arst_n empties the pipeline and the output buffer; no memory needs clearing.
// A stalled result sits in the output register and one more in a skid register;
// pt_ready comes only from the skid register, so a full skid freezes the pipeline.
module cartesian_to_spherical_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pt_valid,
	output logic                                pt_ready,
	input  logic signed [c2s_pkg::COORD_BITS-1:0] x_coord,
	input  logic signed [c2s_pkg::COORD_BITS-1:0] y_coord,
	input  logic signed [c2s_pkg::COORD_BITS-1:0] z_coord,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [c2s_pkg::AZ_W-1:0]            azimuth,
	output logic signed [c2s_pkg::EL_W-1:0]     elevation,
	output logic [c2s_pkg::DIST_W-1:0]          distance
);

	localparam int XY_W   = c2s_pkg::XY_W;
	localparam int SIDE_W = c2s_pkg::SIDE_W;
	localparam int AZ_W   = c2s_pkg::AZ_W;
	localparam int EL_W   = c2s_pkg::EL_W;
	localparam int DIST_W = c2s_pkg::DIST_W;
	localparam int G      = c2s_pkg::COORD_GUARD;
	localparam int DR_W   = XY_W + 1 - G;

	logic advance;

	c2s_pkg::xy_t        x_in;
	c2s_pkg::xy_t        y_in;
	logic [SIDE_W-1:0]   z_in;

	logic                p1_valid;
	c2s_pkg::xy_t        p1_x;
	c2s_pkg::ang_t       p1_angle;
	logic [SIDE_W-1:0]   p1_side;

	c2s_pkg::ang_t       az_sum;
	c2s_pkg::rnd_t       az_rnd;
	c2s_pkg::rnd_t       az_wrap;

	logic                v_s1;
	logic [XY_W-1:0]     r_s1;
	logic [AZ_W-1:0]     az_s1;
	logic [SIDE_W-1:0]   z_s1;

	logic                p2_valid;
	c2s_pkg::xy_t        p2_x;
	c2s_pkg::ang_t       p2_angle;
	logic [SIDE_W-1:0]   p2_side;

	c2s_pkg::ang_t       el_sum;
	c2s_pkg::rnd_t       el_rnd;
	c2s_pkg::el_t        el_sat;

	logic                v_s2;
	logic [XY_W-1:0]     d_s2;
	logic [AZ_W-1:0]     az_s2;
	c2s_pkg::el_t        el_s2;

	logic [XY_W:0]       d_sum;
	logic [DR_W-1:0]     d_rnd;
	logic [DIST_W-1:0]   d_sat;
	logic                load_out;

	logic                out_valid_q;
	logic [AZ_W-1:0]     az_q;
	c2s_pkg::el_t        el_q;
	logic [DIST_W-1:0]   dist_q;
	logic                skid_valid_q;
	logic [AZ_W-1:0]     skid_az_q;
	c2s_pkg::el_t        skid_el_q;
	logic [DIST_W-1:0]   skid_dist_q;

	assign advance  = !skid_valid_q;
	assign pt_ready = advance;

	assign x_in = c2s_pkg::xy_t'(x_coord) <<< G;
	assign y_in = c2s_pkg::xy_t'(y_coord) <<< G;
	assign z_in = {z_coord, {G{1'b0}}};

	c2s_cordic_pass u_pass_az (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.src_valid (pt_valid),
		.src_x     (x_in),
		.src_y     (y_in),
		.src_side  (z_in),
		.dst_valid (p1_valid),
		.dst_x     (p1_x),
		.dst_angle (p1_angle),
		.dst_side  (p1_side)
	);

	// azimuth: round to output scale, wrap into one turn
	always_comb begin
		az_sum = p1_angle + c2s_pkg::ANG_RND_HALF;
		az_rnd = c2s_pkg::rnd_t'(az_sum >>> c2s_pkg::ANGLE_GUARD);
		if (az_rnd < 0)
			az_wrap = az_rnd + c2s_pkg::FULL_TURN;
		else if (az_rnd >= c2s_pkg::FULL_TURN)
			az_wrap = az_rnd - c2s_pkg::FULL_TURN;
		else
			az_wrap = az_rnd;
	end

	c2s_gain u_gain_r (
		.clk     (clk),
		.advance (advance),
		.value   (p1_x),
		.scaled  (r_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= p1_valid;
			v_s2 <= p2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			az_s1 <= az_wrap[AZ_W-1:0];
			z_s1  <= p1_side;
		end
	end

	c2s_cordic_pass u_pass_el (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.src_valid (v_s1),
		.src_x     (c2s_pkg::xy_t'(r_s1)),
		.src_y     (c2s_pkg::xy_t'($signed(z_s1))),
		.src_side  (SIDE_W'(az_s1)),
		.dst_valid (p2_valid),
		.dst_x     (p2_x),
		.dst_angle (p2_angle),
		.dst_side  (p2_side)
	);

	// elevation: round, clamp to a quarter turn
	always_comb begin
		el_sum = p2_angle + c2s_pkg::ANG_RND_HALF;
		el_rnd = c2s_pkg::rnd_t'(el_sum >>> c2s_pkg::ANGLE_GUARD);
		if (el_rnd > c2s_pkg::QUARTER_TURN)
			el_sat = c2s_pkg::EL_MAX;
		else if (el_rnd < -c2s_pkg::QUARTER_TURN)
			el_sat = c2s_pkg::EL_MIN;
		else
			el_sat = c2s_pkg::el_t'(el_rnd);
	end

	c2s_gain u_gain_d (
		.clk     (clk),
		.advance (advance),
		.value   (p2_x),
		.scaled  (d_s2)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			az_s2 <= p2_side[AZ_W-1:0];
			el_s2 <= el_sat;
		end
	end

	always_comb begin
		d_sum = {1'b0, d_s2} + (XY_W + 1)'(1 << (G - 1));
		d_rnd = d_sum[XY_W:G];
		if (d_rnd > DR_W'(c2s_pkg::DIST_MAX))
			d_sat = c2s_pkg::DIST_MAX;
		else
			d_sat = d_rnd[DIST_W-1:0];
	end

	assign load_out = advance && v_s2;

	// output register plus skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !res_ready) begin
			if (load_out)
				skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !res_ready) begin
			if (load_out) begin
				skid_az_q   <= az_s2;
				skid_el_q   <= el_s2;
				skid_dist_q <= d_sat;
			end
		end else if (skid_valid_q) begin
			az_q   <= skid_az_q;
			el_q   <= skid_el_q;
			dist_q <= skid_dist_q;
		end else if (load_out) begin
			az_q   <= az_s2;
			el_q   <= el_s2;
			dist_q <= d_sat;
		end
	end

	assign res_valid = out_valid_q;
	assign azimuth   = az_q;
	assign elevation = el_q;
	assign distance  = dist_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a transfer while output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !res_ready))
		else $error("skid filled without an output stall");

	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (azimuth < AZ_W'(c2s_pkg::FULL_TURN)))
		else $error("azimuth outside one turn");

	a_el_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (elevation <= c2s_pkg::EL_MAX && elevation >= c2s_pkg::EL_MIN))
		else $error("elevation beyond a quarter turn");

endmodule

// ----- dv/c2s_result_checker.sv -----
`timescale 1ns / 1ps

module c2s_result_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   pt_valid,
	input  logic                                   pt_ready,
	input  logic signed [c2s_pkg::COORD_BITS-1:0]  x_coord,
	input  logic signed [c2s_pkg::COORD_BITS-1:0]  y_coord,
	input  logic signed [c2s_pkg::COORD_BITS-1:0]  z_coord,
	input  logic                                   res_valid,
	input  logic                                   res_ready,
	input  logic [c2s_pkg::AZ_W-1:0]               azimuth,
	input  logic signed [c2s_pkg::EL_W-1:0]        elevation,
	input  logic [c2s_pkg::DIST_W-1:0]             distance,
	input  logic                                   sweep_done,
	output int                                     mismatches,
	output int                                     pending
);

	typedef logic signed [c2s_pkg::COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t                              x;
		coord_t                              y;
		coord_t                              z;
		logic [c2s_pkg::AZ_W-1:0]            az;
		logic signed [c2s_pkg::EL_W-1:0]     el;
		logic [c2s_pkg::DIST_W-1:0]          len;
	} spherical_t;

	localparam longint FULL_TURN_Q    = longint'(360) <<< c2s_pkg::ANGLE_FRAC_BITS;
	localparam longint QUARTER_TURN_Q = longint'(90) <<< c2s_pkg::ANGLE_FRAC_BITS;
	localparam longint LEN_MAX        = (longint'(1) <<< c2s_pkg::DIST_W) - 1;

	longint     atan_deg [c2s_pkg::ITERS];
	spherical_t spherical_q [$];
	spherical_t want;

	// atan(2^-i) in degrees with ANGLE_F fraction bits, from the arctangent series
	function automatic longint atan_deg_entry(input int i);
		longint unsigned p, sum, term, rad28, prod, k;
		if (i == 0)
			return longint'(45) <<< c2s_pkg::ANGLE_F;
		p   = 64'd1 << (60 - i);
		sum = 0;
		k   = 0;
		while (p != 0) begin
			term = p / (2 * k + 1);
			if (k % 2 == 0)
				sum = sum + term;
			else
				sum = sum - term;
			p = p >> (2 * i);
			k = k + 1;
		end
		rad28 = (sum + (64'd1 << 31)) >> 32;
		prod  = rad28 * 64'(c2s_pkg::RAD_TO_DEG_Q30);
		return longint'((prod + (64'd1 << (57 - c2s_pkg::ANGLE_F))) >> (58 - c2s_pkg::ANGLE_F));
	endfunction

	// multiply by 1/K, round half up; v is never negative here
	function automatic longint remove_gain(input longint v);
		longint unsigned u, hi, lo, g;
		u  = v;
		g  = 64'(c2s_pkg::INV_GAIN);
		hi = u >> 32;
		lo = u & 64'hFFFF_FFFF;
		return longint'(hi * g + ((lo * g + (64'd1 << 31)) >> 32));
	endfunction

	function automatic longint vector_pass(input longint xi, input longint yi, output longint len);
		longint vx, vy, ang, dx, dy;
		vx  = xi;
		vy  = yi;
		ang = 0;
		len = xi;
		if (vx == 0 && vy == 0)
			return 0;
		if (vx < 0) begin
			vx  = -vx;
			vy  = -vy;
			ang = longint'(180) <<< c2s_pkg::ANGLE_F;
		end
		for (int i = 0; i < c2s_pkg::ITERS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx  = vx + dx;
				vy  = vy - dy;
				ang = ang + atan_deg[i];
			end else begin
				vx  = vx - dx;
				vy  = vy + dy;
				ang = ang - atan_deg[i];
			end
		end
		len = vx;
		return ang;
	endfunction

	function automatic spherical_t convert_point(input coord_t xc, input coord_t yc,
			input coord_t zc);
		spherical_t res;
		longint     px, py, pz, planar, span, r, d, a1, a2, az, el;
		px = longint'(xc) * (longint'(1) <<< c2s_pkg::COORD_GUARD);
		py = longint'(yc) * (longint'(1) <<< c2s_pkg::COORD_GUARD);
		pz = longint'(zc) * (longint'(1) <<< c2s_pkg::COORD_GUARD);
		a1 = vector_pass(px, py, planar);
		r  = remove_gain(planar);
		a2 = vector_pass(r, pz, span);
		d  = remove_gain(span);

		az = (a1 + (longint'(1) <<< (c2s_pkg::ANGLE_GUARD - 1))) >>> c2s_pkg::ANGLE_GUARD;
		if (az < 0)
			az = az + FULL_TURN_Q;
		if (az >= FULL_TURN_Q)
			az = az - FULL_TURN_Q;

		el = (a2 + (longint'(1) <<< (c2s_pkg::ANGLE_GUARD - 1))) >>> c2s_pkg::ANGLE_GUARD;
		if (el > QUARTER_TURN_Q)
			el = QUARTER_TURN_Q;
		if (el < -QUARTER_TURN_Q)
			el = -QUARTER_TURN_Q;

		d = (d + (longint'(1) <<< (c2s_pkg::COORD_GUARD - 1))) >>> c2s_pkg::COORD_GUARD;
		if (d > LEN_MAX)
			d = LEN_MAX;

		res.x   = xc;
		res.y   = yc;
		res.z   = zc;
		res.az  = az[c2s_pkg::AZ_W-1:0];
		res.el  = el[c2s_pkg::EL_W-1:0];
		res.len = d[c2s_pkg::DIST_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	initial begin
		for (int i = 0; i < c2s_pkg::ITERS; i++)
			atan_deg[i] = atan_deg_entry(i);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (spherical_q.size() == 0) begin
					report_mismatch($sformatf("result transfer (%0d,%0d,%0d) with no point outstanding",
						azimuth, elevation, distance));
				end else begin
					want = spherical_q.pop_front();
					if (azimuth !== want.az)
						report_mismatch($sformatf("azimuth %0d, predicted %0d for (%0d,%0d,%0d)",
							azimuth, want.az, want.x, want.y, want.z));
					if (elevation !== want.el)
						report_mismatch($sformatf("elevation %0d, predicted %0d for (%0d,%0d,%0d)",
							elevation, want.el, want.x, want.y, want.z));
					if (distance !== want.len)
						report_mismatch($sformatf("distance %0d, predicted %0d for (%0d,%0d,%0d)",
							distance, want.len, want.x, want.y, want.z));
				end
			end
			if (pt_valid && pt_ready)
				spherical_q.push_back(convert_point(x_coord, y_coord, z_coord));
			pending <= spherical_q.size();
		end
	end

	always @(posedge sweep_done) begin
		if (spherical_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", spherical_q.size()));
	end

endmodule

// ----- dv/cartesian_to_spherical_core_test.sv -----
`timescale 1ns / 1ps

module cartesian_to_spherical_core_test;

	typedef logic signed [c2s_pkg::COORD_BITS-1:0] coord_t;

	localparam int C_MAX            = (1 << (c2s_pkg::COORD_BITS - 1)) - 1;
	localparam int C_MIN            = -(1 << (c2s_pkg::COORD_BITS - 1));
	localparam int RANDOM_PER_PHASE = 234;
	localparam int LATENCY          = 2 * (c2s_pkg::CORDIC_ITERATIONS + 1) + 3;
	localparam int HOLD_CYCLES      = 300;

	logic                                clk        = 1'b0;
	logic                                arst_n     = 1'b0;
	logic                                pt_valid   = 1'b0;
	logic                                pt_ready;
	coord_t                              x_coord    = '0;
	coord_t                              y_coord    = '0;
	coord_t                              z_coord    = '0;
	logic                                res_valid;
	logic                                res_ready  = 1'b0;
	logic [c2s_pkg::AZ_W-1:0]            azimuth;
	logic signed [c2s_pkg::EL_W-1:0]     elevation;
	logic [c2s_pkg::DIST_W-1:0]          distance;
	logic                                sweep_done = 1'b0;
	int                                  mismatches;
	int                                  pending;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_output   = 1'b0;

	cartesian_to_spherical_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_ready  (pt_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.azimuth   (azimuth),
		.elevation (elevation),
		.distance  (distance)
	);

	c2s_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_ready   (pt_ready),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.azimuth    (azimuth),
		.elevation  (elevation),
		.distance   (distance),
		.sweep_done (sweep_done),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random back-pressure, or a long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_output) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic offer_point(input int xc, input int yc, input int zc);
		while ($urandom_range(99) < send_idle_pct) begin
			pt_valid <= 1'b0;
			@(posedge clk);
		end
		pt_valid <= 1'b1;
		x_coord  <= coord_t'(xc);
		y_coord  <= coord_t'(yc);
		z_coord  <= coord_t'(zc);
		do
			@(posedge clk);
		while (!pt_ready);
	endtask

	function automatic int random_coord();
		coord_t v;
		v = coord_t'($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3: return int'(v);
			4, 5:       return int'($urandom_range(64)) - 32;
			6:          return 0;
			7:          return $urandom_range(1) ? C_MAX : C_MIN;
			default:    return int'(v >>> $urandom_range(c2s_pkg::COORD_BITS - 1));
		endcase
	endfunction

	initial begin
		int send_pct [3];
		int recv_pct [3];
		send_pct = '{26, 55, 0};
		recv_pct = '{55, 26, 0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = send_pct[0];
		recv_idle_pct = recv_pct[0];

		// origin, axis extremes, octant corners, left half-plane, wrap near 360, poles
		offer_point(0, 0, 0);
		offer_point(C_MAX, 0, 0);
		offer_point(C_MIN, 0, 0);
		offer_point(0, C_MAX, 0);
		offer_point(0, C_MIN, 0);
		offer_point(0, 0, C_MAX);
		offer_point(0, 0, C_MIN);
		offer_point(C_MAX, C_MAX, C_MAX);
		offer_point(C_MIN, C_MIN, C_MIN);
		offer_point(C_MIN, C_MAX, C_MIN);
		offer_point(C_MAX, C_MIN, C_MAX);
		offer_point(-1, 0, 0);
		offer_point(-1, -1, 0);
		offer_point(-5, 3, -7);
		offer_point(1, -1, 0);
		offer_point(C_MAX, -1, 0);
		offer_point(C_MIN, -1, 1);
		offer_point(C_MIN, 1, -1);
		offer_point(0, 0, 1);
		offer_point(0, 0, -1);
		offer_point(1, 0, 0);
		offer_point(3, 4, 12);
		offer_point(-3, -4, -12);
		offer_point(1, 1, C_MAX);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_idle_pct = recv_pct[ph];
			if (ph == 2)
				hold_output = 1'b1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				offer_point(random_coord(), random_coord(), random_coord());
		end
		pt_valid <= 1'b0;

		for (int n = 0; n < 20000 && pending != 0; n++)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		sweep_done <= 1'b1;
		repeat (2) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- cartesian_to_spherical_core.f -----
rtl/c2s_pkg.sv
rtl/c2s_gain.sv
rtl/c2s_cordic_pass.sv
rtl/cartesian_to_spherical_core.sv
dv/c2s_result_checker.sv
dv/cartesian_to_spherical_core_test.sv
